// ===== rtl/core/lnde_pkg.sv =====
// ----------------------------------------------------------------------------
// lnde_pkg
// Shared types, constants and helpers for the LCD number digit emitter.
// ----------------------------------------------------------------------------
package lnde_pkg;

    localparam int unsigned LNDE_QUEUE_DEPTH = 2;
    localparam int unsigned NUM_DIGITS       = 5;

    localparam logic [7:0]  LCD_SET_ADDR = 8'h80;
    localparam logic [2:0]  DEC_MAX_DIGITS = 3'd5;
    localparam logic [2:0]  HEX_MAX_DIGITS = 3'd4;
    localparam logic [2:0]  LAST_DIGIT_IDX = 3'(NUM_DIGITS - 1);

    // q = (v * 52429) >> 19 is exact for any 16-bit v
    localparam logic [16:0] DEC_RECIP = 17'd52429;
    localparam int unsigned DEC_SHIFT = 19;

    localparam logic [7:0]  ASCII_ZERO   = 8'h30;
    localparam logic [7:0]  ASCII_A_LESS = 8'h37;   // 'A' - 10

    typedef struct packed {
        logic [6:0]                  pos;
        logic [2:0]                  cnt;
        logic [NUM_DIGITS-1:0][7:0]  digits;   // index 0 is least significant
    } lnde_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lnde_qstat_t;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'b0, nib};
        if (nib > 4'd9)
            return wide + ASCII_A_LESS;
        else
            return wide + ASCII_ZERO;
    endfunction

endpackage

// ===== rtl/core/lcd_number_digit_emitter.sv =====
// ----------------------------------------------------------------------------
// lcd_number_digit_emitter
// Turns a 16-bit number into a set-address command and ASCII digits for a
// character LCD.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                              | tuser   | tlast
//  s_*     | in        | position, number, digit_count      | func    | -
//  m_*     | out       | lcd_byte                           | is_data | last
//
// Front: accepts a word, then converts its five digits one after another (a
// 16x17 reciprocal multiply for decimal) and hands the result to the queue.
// Back: sends the set-address command and then the digits for each number.
// The queue lets the front convert the next number while the back sends.
// A stalled m_tready holds the output register; the front stops once the
// queue is full. rst_n is asynchronous and clears all control state.
// ----------------------------------------------------------------------------
module lcd_number_digit_emitter
    import lnde_pkg::*;
#(
    parameter int unsigned QueueDepth = LNDE_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [6:0] position, [22:7] number, [25:23] digit_count
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] lcd_byte
    output logic        m_tuser,   // [0] is_data
    output logic        m_tlast
);

    lnde_qstat_t q_stat;
    lnde_entry_t push_entry;
    lnde_entry_t pop_entry;
    logic        q_push;
    logic        q_pop;

    lnde_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_hex     (s_tuser),
        .in_pos     (s_tdata[6:0]),
        .in_number  (s_tdata[22:7]),
        .in_count   (s_tdata[25:23]),
        .q_stat     (q_stat),
        .push       (q_push),
        .push_entry (push_entry)
    );

    lnde_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    lnde_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .pop_entry   (pop_entry),
        .pop         (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_is_data (m_tuser),
        .out_byte    (m_tdata),
        .out_last    (m_tlast)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_pop_is_command: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> m_tvalid && !m_tuser)
        else $error("run does not open with a command word");
`endif

endmodule

// ===== rtl/core/lnde_front.sv =====
// ----------------------------------------------------------------------------
// lnde_front
// Accepts a word, saturates the digit count and converts the number into
// five ASCII digits, one per cycle, then hands the result to the queue.
// ----------------------------------------------------------------------------
module lnde_front
    import lnde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_hex,
    input  logic [6:0]  in_pos,
    input  logic [15:0] in_number,
    input  logic [2:0]  in_count,
    input  lnde_qstat_t q_stat,
    output logic        push,
    output lnde_entry_t push_entry
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

    front_state_t               state_reg;
    logic                       hex_reg;
    logic [6:0]                 pos_reg;
    logic [2:0]                 cnt_reg;
    logic [15:0]                value_reg;
    logic [2:0]                 idx_reg;
    logic [NUM_DIGITS-1:0][7:0] digits_reg;

    logic [32:0] product;
    logic [15:0] quot;
    logic [15:0] quot_x10;
    logic [15:0] rem_wide;
    logic [3:0]  digit;
    logic [15:0] value_next;
    logic [2:0]  cnt_sat;

    always_comb
    begin
        product  = 33'(value_reg) * 33'(DEC_RECIP);
        quot     = {2'b0, product[32:DEC_SHIFT]};
        quot_x10 = {quot[12:0], 3'b0} + {quot[14:0], 1'b0};
        rem_wide = value_reg - quot_x10;
        if (hex_reg)
        begin
            digit      = value_reg[3:0];
            value_next = {4'b0, value_reg[15:4]};
        end
        else
        begin
            digit      = rem_wide[3:0];
            value_next = quot;
        end
    end

    always_comb
    begin
        if (in_hex)
            cnt_sat = (in_count > HEX_MAX_DIGITS) ? HEX_MAX_DIGITS : in_count;
        else
            cnt_sat = (in_count > DEC_MAX_DIGITS) ? DEC_MAX_DIGITS : in_count;
    end

    assign in_ready          = (state_reg == F_IDLE);
    assign push              = (state_reg == F_PUSH) && !q_stat.full;
    assign push_entry.pos    = pos_reg;
    assign push_entry.cnt    = cnt_reg;
    assign push_entry.digits = digits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= F_CONV;
                        idx_reg   <= '0;
                    end
                end
                F_CONV:
                begin
                    idx_reg <= idx_reg + 3'd1;
                    if (idx_reg == LAST_DIGIT_IDX)
                        state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_stat.full)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            hex_reg   <= in_hex;
            pos_reg   <= in_pos;
            cnt_reg   <= cnt_sat;
            value_reg <= in_number;
        end
        else if (state_reg == F_CONV)
        begin
            digits_reg[idx_reg] <= digit_to_ascii(digit);
            value_reg           <= value_next;
        end
    end

endmodule

// ===== rtl/core/lnde_queue.sv =====
// ----------------------------------------------------------------------------
// lnde_queue
// Short queue of converted numbers between front and back.
// ----------------------------------------------------------------------------
module lnde_queue
    import lnde_pkg::*;
#(
    parameter int unsigned Depth = LNDE_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  lnde_entry_t push_entry,
    input  logic        pop,
    output lnde_entry_t pop_entry,
    output lnde_qstat_t q_stat
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    lnde_entry_t     mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign q_stat.full  = (count_reg == CntFull);
    assign q_stat.empty = (count_reg == '0);
    assign pop_entry    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/core/lnde_back.sv =====
// ----------------------------------------------------------------------------
// lnde_back
// Takes a converted number from the queue and sends the address command
// followed by the digits, most significant first, through an output register.
// ----------------------------------------------------------------------------
module lnde_back
    import lnde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lnde_qstat_t q_stat,
    input  lnde_entry_t pop_entry,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_is_data,
    output logic [7:0]  out_byte,
    output logic        out_last
);

    typedef enum logic {
        B_IDLE,
        B_RUN
    } back_state_t;

    back_state_t state_reg;
    lnde_entry_t entry_reg;
    logic [2:0]  idx_reg;
    logic        valid_reg;
    logic        is_data_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    logic can_load;

    assign can_load    = !valid_reg || out_ready;
    assign pop         = (state_reg == B_IDLE) && can_load && !q_stat.empty;
    assign out_valid   = valid_reg;
    assign out_is_data = is_data_reg;
    assign out_byte    = byte_reg;
    assign out_last    = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (can_load)
        begin
            case (state_reg)
                B_IDLE:
                begin
                    valid_reg <= !q_stat.empty;
                    if (!q_stat.empty)
                    begin
                        idx_reg <= pop_entry.cnt;
                        if (pop_entry.cnt != 3'd0)
                            state_reg <= B_RUN;
                    end
                end
                B_RUN:
                begin
                    valid_reg <= 1'b1;
                    idx_reg   <= idx_reg - 3'd1;
                    if (idx_reg == 3'd1)
                        state_reg <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                    valid_reg <= 1'b0;
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            entry_reg   <= pop_entry;
            is_data_reg <= 1'b0;
            byte_reg    <= LCD_SET_ADDR | {1'b0, pop_entry.pos};
            last_reg    <= (pop_entry.cnt == 3'd0);
        end
        else if (can_load && state_reg == B_RUN)
        begin
            is_data_reg <= 1'b1;
            byte_reg    <= entry_reg.digits[idx_reg - 3'd1];
            last_reg    <= (idx_reg == 3'd1);
        end
    end

endmodule
